@@ hw/rtl/fqs_pkg.sv @@
package fqs_pkg;

  localparam int TIN_SLOTS     = 8;
  localparam int FLOWS_PER_TIN = 1024;
  localparam int DESCRIPTORS   = 1024;
  localparam int TOTAL_FLOWS   = TIN_SLOTS * FLOWS_PER_TIN;

  localparam int TIN_W   = (TIN_SLOTS > 1) ? $clog2(TIN_SLOTS) : 1;
  localparam int FLOW_W  = $clog2(FLOWS_PER_TIN);
  localparam int DESC_W  = $clog2(DESCRIPTORS);
  localparam int CNT_W   = $clog2(DESCRIPTORS + 1);
  localparam int GFLOW_W = $clog2(TOTAL_FLOWS);
  localparam int SERVE_W = 4;

  // flow table entry: head, tail, packet count
  localparam int FLOW_ENT_W = 2 * DESC_W + CNT_W;

  localparam int ID_W    = 16;
  localparam int LEN_W   = 16;
  localparam int DSCP_W  = 6;
  localparam int HASH_W  = 32;
  localparam int LIMIT_W = 32;
  localparam int STAT_W  = 3;
  localparam int OTIN_W  = 3;

  // configuration register indexes
  localparam logic REG_BYTE_LIMIT = 1'b0;
  localparam logic REG_TIN_COUNT  = 1'b1;

  localparam logic [LIMIT_W-1:0] BYTE_LIMIT_RST = 32'd4194304;
  localparam logic [3:0]         TIN_COUNT_RST  = 4'd3;
  localparam logic [3:0]         DSCP_TINS      = 4'd3;
  localparam logic [DSCP_W-1:0]  DSCP_CLASS_HI  = 6'd32;
  localparam logic [DSCP_W-1:0]  DSCP_CLASS_MID = 6'd8;

  // result status codes
  localparam logic [STAT_W-1:0] ST_ENQ        = 3'd0;
  localparam logic [STAT_W-1:0] ST_DROP_LIMIT = 3'd1;
  localparam logic [STAT_W-1:0] ST_DROP_DESC  = 3'd2;
  localparam logic [STAT_W-1:0] ST_DEQ        = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY      = 3'd4;

  localparam logic MODE_ENQ = 1'b0;

  typedef struct packed {
    logic              valid;
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   packet_id;
    logic [LEN_W-1:0]  length;
    logic [OTIN_W-1:0] tin;
  } res_t;

  typedef struct packed {
    logic [TIN_W-1:0]   tin;
    logic [FLOW_W-1:0]  flow;
    logic [SERVE_W-1:0] served;
  } cls_t;

endpackage

@@ hw/rtl/fqs_classify.sv @@
module fqs_classify import fqs_pkg::*; (
  input  logic [DSCP_W-1:0] dscp,
  input  logic [HASH_W-1:0] flow_hash,
  input  logic [ID_W-1:0]   packet_id,
  input  logic [3:0]        tin_count,
  output cls_t              cls
);

  logic [3:0]        tin_w;
  logic [HASH_W-1:0] key;

  // DSCP classes only with three tins, then clamp to the tin range
  always_comb begin
    tin_w = 4'd0;
    if (tin_count == DSCP_TINS) begin
      if (dscp >= DSCP_CLASS_HI)       tin_w = 4'd0;
      else if (dscp >= DSCP_CLASS_MID) tin_w = 4'd1;
      else                             tin_w = 4'd2;
    end
    if (tin_w > 4'(TIN_SLOTS - 1)) tin_w = 4'(TIN_SLOTS - 1);
  end

  assign key        = (flow_hash == '0) ? HASH_W'(packet_id) : flow_hash;
  assign cls.tin    = tin_w[TIN_W-1:0];
  assign cls.flow   = key[FLOW_W-1:0];
  assign cls.served = (tin_count > 4'(TIN_SLOTS)) ? SERVE_W'(TIN_SLOTS) : tin_count;

endmodule

@@ hw/rtl/fqs_engine.sv @@
module fqs_engine import fqs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               mode,
  input  logic [ID_W-1:0]    packet_id,
  input  logic [LEN_W-1:0]   packet_length,
  input  cls_t               cls,
  input  logic [LIMIT_W-1:0] byte_limit,
  input  logic               out_free,
  output res_t               res
);

  typedef enum logic [1:0] {S_IDLE, S_ENQ, S_DRD, S_DEQ} state_t;

  // memories
  logic [DESC_W-1:0]      free_ring [DESCRIPTORS];
  logic [ID_W+LEN_W-1:0]  desc_data [DESCRIPTORS];
  logic [DESC_W-1:0]      desc_next [DESCRIPTORS];
  logic [FLOW_ENT_W-1:0]  flow_mem  [TOTAL_FLOWS];
  logic [FLOW_W-1:0]      flow_link [TOTAL_FLOWS];

  // control state
  state_t             state_r;
  logic               clr_r;
  logic [GFLOW_W-1:0] clr_idx_r;
  logic [DESC_W-1:0]  free_rd_r, free_wr_r;
  logic [CNT_W-1:0]   free_cnt_r;
  logic               wrapped_r;
  logic [LIMIT_W-1:0] bytes_r;
  logic [FLOW_W-1:0]  new_hd_r [TIN_SLOTS];
  logic [FLOW_W-1:0]  new_tl_r [TIN_SLOTS];
  logic [TIN_SLOTS-1:0] new_ne_r;
  logic [FLOW_W-1:0]  old_hd_r [TIN_SLOTS];
  logic [FLOW_W-1:0]  old_tl_r [TIN_SLOTS];
  logic [TIN_SLOTS-1:0] old_ne_r;

  // item registers and read data
  logic [TIN_W-1:0]   tin_r;
  logic [FLOW_W-1:0]  flow_r;
  logic [ID_W-1:0]    id_r;
  logic [LEN_W-1:0]   len_r;
  logic               from_new_r;
  logic               ring_sel_r;
  logic [DESC_W-1:0]  ring_idx_r;
  logic [DESC_W-1:0]  ring_q;
  logic [FLOW_ENT_W-1:0] flow_q;
  logic [FLOW_W-1:0]  link_q;
  logic [ID_W+LEN_W-1:0] data_q;
  logic [DESC_W-1:0]  next_q;

  logic               acc;
  logic               over, nodesc;
  logic               found, pick_new;
  logic [TIN_W-1:0]   pick_t;
  logic [FLOW_W-1:0]  pick_f;
  logic [GFLOW_W-1:0] flow_raddr;
  logic [DESC_W-1:0]  fq_head, fq_tail, new_d;
  logic [CNT_W-1:0]   fq_cnt, cnt_dec;
  logic [LEN_W-1:0]   dq_len;
  res_t               res_nxt;

  // list updates for a dequeue
  logic [FLOW_W-1:0]  n_hd, o_hd, o_tl;
  logic               n_ne, o_ne;

  // memory write controls
  logic               fw_en, lw_en;
  logic [GFLOW_W-1:0] fw_addr, lw_addr;
  logic [FLOW_ENT_W-1:0] fw_data;
  logic [FLOW_W-1:0]  lw_data;
  logic               enq_go, deq_go;

  assign in_stall = clr_r || (state_r != S_IDLE) || !out_free;
  assign acc      = in_valid && !in_stall;

  assign over   = ({1'b0, bytes_r} + (LIMIT_W + 1)'(packet_length)) > {1'b0, byte_limit};
  assign nodesc = (free_cnt_r == '0);

  // highest priority served tin with a backlogged flow
  always_comb begin
    found  = 1'b0;
    pick_t = '0;
    for (int i = TIN_SLOTS - 1; i >= 0; i--) begin
      if ((SERVE_W'(i) < cls.served) && (new_ne_r[i] || old_ne_r[i])) begin
        found  = 1'b1;
        pick_t = TIN_W'(i);
      end
    end
    pick_new = new_ne_r[pick_t];
    pick_f   = pick_new ? new_hd_r[pick_t] : old_hd_r[pick_t];
  end

  assign flow_raddr = (mode == MODE_ENQ) ? {cls.tin, cls.flow} : {pick_t, pick_f};

  assign fq_head = flow_q[FLOW_ENT_W-1 -: DESC_W];
  assign fq_tail = flow_q[CNT_W +: DESC_W];
  assign fq_cnt  = flow_q[CNT_W-1:0];
  assign cnt_dec = fq_cnt - CNT_W'(1);
  assign new_d   = ring_sel_r ? ring_q : ring_idx_r;
  assign dq_len  = data_q[LEN_W-1:0];

  assign enq_go = (state_r == S_ENQ) && out_free;
  assign deq_go = (state_r == S_DEQ) && out_free;

  // pop the served flow, then re-append it to the old list if backlogged
  always_comb begin
    n_hd = new_hd_r[tin_r];
    n_ne = new_ne_r[tin_r];
    o_hd = old_hd_r[tin_r];
    o_tl = old_tl_r[tin_r];
    o_ne = old_ne_r[tin_r];
    lw_en   = 1'b0;
    lw_addr = {tin_r, o_tl};
    lw_data = flow_r;
    if (from_new_r) begin
      if (new_hd_r[tin_r] == new_tl_r[tin_r]) n_ne = 1'b0;
      else                                   n_hd = link_q;
    end else begin
      if (old_hd_r[tin_r] == old_tl_r[tin_r]) o_ne = 1'b0;
      else                                   o_hd = link_q;
    end
    if (cnt_dec != '0) begin
      if (o_ne) begin
        lw_en   = 1'b1;
        lw_addr = {tin_r, o_tl};
      end else begin
        o_hd = flow_r;
      end
      o_tl = flow_r;
      o_ne = 1'b1;
    end
    if (state_r == S_ENQ) begin
      // new flow joins its tin's new list
      lw_en   = (fq_cnt == '0) && new_ne_r[tin_r];
      lw_addr = {tin_r, new_tl_r[tin_r]};
      lw_data = flow_r;
    end
    lw_en = lw_en && (enq_go || deq_go);
  end

  // flow table write port: clearing pass, enqueue or dequeue
  always_comb begin
    fw_en   = 1'b0;
    fw_addr = {tin_r, flow_r};
    fw_data = '0;
    if (clr_r) begin
      fw_en   = 1'b1;
      fw_addr = clr_idx_r;
    end else if (enq_go) begin
      fw_en   = 1'b1;
      fw_data = {(fq_cnt == '0) ? new_d : fq_head, new_d, fq_cnt + CNT_W'(1)};
    end else if (deq_go) begin
      fw_en   = 1'b1;
      fw_data = {next_q, fq_tail, cnt_dec};
    end
  end

  // result word for this cycle
  always_comb begin
    res_nxt = '0;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (mode == MODE_ENQ) begin
            if (over || nodesc) begin
              res_nxt.valid  = 1'b1;
              res_nxt.status = over ? ST_DROP_LIMIT : ST_DROP_DESC;
              res_nxt.tin    = OTIN_W'(cls.tin);
            end
          end else if (!found) begin
            res_nxt.valid  = 1'b1;
            res_nxt.status = ST_EMPTY;
          end
        end
      end
      S_ENQ: begin
        if (out_free) begin
          res_nxt.valid  = 1'b1;
          res_nxt.status = ST_ENQ;
          res_nxt.tin    = OTIN_W'(tin_r);
        end
      end
      S_DEQ: begin
        if (out_free) begin
          res_nxt.valid     = 1'b1;
          res_nxt.status    = ST_DEQ;
          res_nxt.packet_id = data_q[ID_W+LEN_W-1:LEN_W];
          res_nxt.length    = dq_len;
          res_nxt.tin       = OTIN_W'(tin_r);
        end
      end
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (acc) begin
      ring_q <= free_ring[free_rd_r];
      flow_q <= flow_mem[flow_raddr];
      link_q <= flow_link[{pick_t, pick_f}];
    end
    if (state_r == S_DRD) begin
      data_q <= desc_data[fq_head];
      next_q <= desc_next[fq_head];
    end
    if (fw_en) flow_mem[fw_addr] <= fw_data;
    if (lw_en) flow_link[lw_addr] <= lw_data;
    if (enq_go) begin
      desc_data[new_d] <= {id_r, len_r};
      if (fq_cnt != '0) desc_next[fq_tail] <= new_d;
    end
    if (deq_go) free_ring[free_wr_r] <= fq_head;
  end

  // item registers
  always_ff @(posedge clk) begin
    if (acc) begin
      tin_r      <= (mode == MODE_ENQ) ? cls.tin : pick_t;
      flow_r     <= (mode == MODE_ENQ) ? cls.flow : pick_f;
      id_r       <= packet_id;
      len_r      <= packet_length;
      from_new_r <= pick_new;
      ring_sel_r <= wrapped_r || (free_rd_r < free_wr_r);
      ring_idx_r <= free_rd_r;
    end
  end

  // sequencer and queue bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      clr_r      <= 1'b1;
      clr_idx_r  <= '0;
      free_rd_r  <= '0;
      free_wr_r  <= '0;
      free_cnt_r <= CNT_W'(DESCRIPTORS);
      wrapped_r  <= 1'b0;
      bytes_r    <= '0;
      new_ne_r   <= '0;
      old_ne_r   <= '0;
      for (int i = 0; i < TIN_SLOTS; i++) begin
        new_hd_r[i] <= '0;
        new_tl_r[i] <= '0;
        old_hd_r[i] <= '0;
        old_tl_r[i] <= '0;
      end
      res <= '0;
    end else begin
      res <= res_nxt;
      if (clr_r) begin
        clr_idx_r <= clr_idx_r + GFLOW_W'(1);
        if (clr_idx_r == GFLOW_W'(TOTAL_FLOWS - 1)) clr_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (acc) begin
            if (mode == MODE_ENQ) begin
              if (!(over || nodesc)) state_r <= S_ENQ;
            end else if (found) begin
              state_r <= S_DRD;
            end
          end
        end
        S_ENQ: begin
          if (out_free) begin
            state_r    <= S_IDLE;
            free_rd_r  <= (free_rd_r == DESC_W'(DESCRIPTORS - 1)) ? '0
                                                                  : free_rd_r + DESC_W'(1);
            free_cnt_r <= free_cnt_r - CNT_W'(1);
            bytes_r    <= bytes_r + LIMIT_W'(len_r);
            if (fq_cnt == '0) begin
              if (!new_ne_r[tin_r]) new_hd_r[tin_r] <= flow_r;
              new_tl_r[tin_r] <= flow_r;
              new_ne_r[tin_r] <= 1'b1;
            end
          end
        end
        S_DRD: begin
          state_r <= S_DEQ;
        end
        S_DEQ: begin
          if (out_free) begin
            state_r    <= S_IDLE;
            if (free_wr_r == DESC_W'(DESCRIPTORS - 1)) begin
              free_wr_r <= '0;
              wrapped_r <= 1'b1;
            end else begin
              free_wr_r <= free_wr_r + DESC_W'(1);
            end
            free_cnt_r <= free_cnt_r + CNT_W'(1);
            bytes_r    <= bytes_r - LIMIT_W'(dq_len);
            new_hd_r[tin_r] <= n_hd;
            new_ne_r[tin_r] <= n_ne;
            old_hd_r[tin_r] <= o_hd;
            old_tl_r[tin_r] <= o_tl;
            old_ne_r[tin_r] <= o_ne;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/flow_queue_packet_scheduler.sv @@
// Channel  Direction  Handshake          Word
// in_      input      in_valid/in_stall   mode, id, length, dscp, flow hash
// out_     output     out_valid/out_stall status, id, length, tin
// cfg_     input      cfg_valid/cfg_ready register index, 32-bit data
//
// One item at a time. A drop or an empty answer is decided on acceptance, an
// enqueue after the flow table read, a dequeue after the flow table read and
// the descriptor read, with the write-back in that final state; the result
// word goes through the engine's result register into the output register.
// After reset the flow table is cleared, one entry a cycle, with in_stall high
// throughout. Configuration writes are taken at any time (cfg_ready high).
// A stalled result holds the output register; the next item waits for it.
module flow_queue_packet_scheduler import fqs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_mode,
  input  logic [ID_W-1:0]    in_packet_id,
  input  logic [LEN_W-1:0]   in_packet_length,
  input  logic [DSCP_W-1:0]  in_dscp,
  input  logic [HASH_W-1:0]  in_flow_hash,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [STAT_W-1:0]  out_status,
  output logic [ID_W-1:0]    out_packet_id,
  output logic [LEN_W-1:0]   out_length,
  output logic [OTIN_W-1:0]  out_tin,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [LIMIT_W-1:0] cfg_data
);

  logic [LIMIT_W-1:0] byte_limit_r;
  logic [3:0]         tin_count_r;
  cls_t               cls;
  res_t               res;
  res_t               out_r;
  logic               out_free;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_limit_r <= BYTE_LIMIT_RST;
      tin_count_r  <= TIN_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BYTE_LIMIT: byte_limit_r <= cfg_data;
        REG_TIN_COUNT:  tin_count_r  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  fqs_classify u_cls (
    .dscp      (in_dscp),
    .flow_hash (in_flow_hash),
    .packet_id (in_packet_id),
    .tin_count (tin_count_r),
    .cls       (cls)
  );

  fqs_engine u_eng (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mode          (in_mode),
    .packet_id     (in_packet_id),
    .packet_length (in_packet_length),
    .cls           (cls),
    .byte_limit    (byte_limit_r),
    .out_free      (out_free),
    .res           (res)
  );

  // output register; a word still on its way in counts as occupied
  assign out_free = !res.valid && (!out_r.valid || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r <= '0;
    end else if (res.valid) begin
      out_r <= res;
    end else if (!out_stall) begin
      out_r.valid <= 1'b0;
    end
  end

  assign out_valid     = out_r.valid;
  assign out_status    = out_r.status;
  assign out_packet_id = out_r.packet_id;
  assign out_length    = out_r.length;
  assign out_tin       = out_r.tin;

  // checks
  a_no_accept_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !(out_valid && out_stall))
    else $error("item taken while result is stalled");

  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input open during table clear");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !res.valid)
    else $error("new result while output stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (res.status <= ST_EMPTY))
    else $error("bad status code");

endmodule
